>>> hw/rtl/triggered_waveform_capture_macros.svh
// Assertion macros for the triggered waveform capture block.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef TRIGGERED_WAVEFORM_CAPTURE_MACROS_SVH
`define TRIGGERED_WAVEFORM_CAPTURE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/twc_pkg.sv
// Shared constants and codes for the triggered waveform capture block.
// No dependencies.
`default_nettype none

package twc_pkg;

  localparam int BUF_DEPTH  = 1024;
  localparam int ADDR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W      = ADDR_W + 1;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 3;
  localparam int DEC_W      = 16;
  localparam int POST_W     = 11;
  localparam int STATE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [STATE_W-1:0] mode_t;

  localparam cmd_t CMD_TICK  = 3'd0;
  localparam cmd_t CMD_START = 3'd1;
  localparam cmd_t CMD_FORCE = 3'd2;
  localparam cmd_t CMD_SWTRIG = 3'd3;
  localparam cmd_t CMD_READ  = 3'd4;
  localparam cmd_t CMD_IDLE  = 3'd5;

  localparam mode_t MODE_IDLE = 2'd0;
  localparam mode_t MODE_WAIT = 2'd1;
  localparam mode_t MODE_POST = 2'd2;
  localparam mode_t MODE_DONE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_LENGTH = 2'd1;

endpackage

`default_nettype wire

>>> hw/rtl/twc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module twc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/triggered_waveform_capture.sv
// Top level of the triggered waveform capture channel.
// Depends on twc_pkg, twc_ram and triggered_waveform_capture_macros.svh.
`default_nettype none

// One command transaction is taken per clock and each gives exactly one result
// transaction in the next cycle via the output register, so the sustained rate
// is one command per cycle; input stalls only while a result waits on a stalled
// output. The sample ring is a 1024 x 32 RAM with one write and one registered
// read port; each command does at most one of them. No clearing pass follows
// reset: a fill count marks the prefix of the ring written since reset, and
// entries above it read as zero. The block is usable from the first cycle after
// reset. Register writes are always accepted; indices 0 and 1 idle the channel.

`include "triggered_waveform_capture_macros.svh"

module triggered_waveform_capture (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [twc_pkg::CMD_W-1:0]        command,
  input  wire logic [twc_pkg::DATA_W-1:0]       sample_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [twc_pkg::DATA_W-1:0]       read_data,
  output logic                                  read_valid,
  output logic                                  read_last,
  output logic      [twc_pkg::STATE_W-1:0]      capture_state,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [twc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [twc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import twc_pkg::*;

  logic              in_accept;
  mode_t             mode, mode_next;
  addr_t             wp, wp_next;
  addr_t             read_offset, read_offset_next;
  cnt_t              fill, fill_next;
  cnt_t              remaining, remaining_next;
  cnt_t              post_length, post_length_next;
  logic [DEC_W-1:0]  decimation, decimation_next;
  logic [DEC_W-1:0]  tick_count, tick_count_next;
  logic [DEC_W-1:0]  tick_inc;
  cnt_t              rem_dec;
  logic [SUM_W-1:0]  idx_sum;
  addr_t             rd_addr;
  logic              store_en;
  logic              rd_en;
  logic              rd_last_next;
  logic              rd_written_next;
  logic              rd_hit;
  logic              rd_written;
  data_t             mem_q;
  logic [POST_W-1:0] post_raw;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign tick_inc = tick_count + DEC_W'(1);
  assign rem_dec  = (remaining != '0) ? remaining - CNT_W'(1) : remaining;
  assign idx_sum  = SUM_W'(wp) + SUM_W'(read_offset);
  assign rd_addr  = (idx_sum >= SUM_W'(BUF_DEPTH)) ? ADDR_W'(idx_sum - SUM_W'(BUF_DEPTH))
                                                   : ADDR_W'(idx_sum);
  assign post_raw = cfg_data[POST_W-1:0];

  always_comb begin
    mode_next        = mode;
    wp_next          = wp;
    read_offset_next = read_offset;
    fill_next        = fill;
    remaining_next   = remaining;
    tick_count_next  = tick_count;
    decimation_next  = decimation;
    post_length_next = post_length;
    store_en         = 1'b0;
    rd_en            = 1'b0;
    rd_last_next     = 1'b0;
    rd_written_next  = 1'b0;

    if (in_accept) begin
      unique case (command)
        CMD_TICK: begin
          if (mode == MODE_WAIT || mode == MODE_POST) begin
            if (tick_inc < decimation) begin
              tick_count_next = tick_inc;
            end else begin
              tick_count_next = '0;
              store_en        = 1'b1;
              wp_next         = (wp == ADDR_W'(BUF_DEPTH - 1)) ? '0 : wp + ADDR_W'(1);
              if (CNT_W'(wp) >= fill) begin
                fill_next = CNT_W'(wp) + CNT_W'(1);
              end
              if (mode == MODE_POST) begin
                remaining_next = rem_dec;
                if (rem_dec == '0) begin
                  mode_next        = MODE_DONE;
                  read_offset_next = '0;
                end
              end
            end
          end
        end
        CMD_START: begin
          if (mode == MODE_IDLE) begin
            tick_count_next  = '0;
            wp_next          = '0;
            read_offset_next = '0;
            mode_next        = MODE_WAIT;
          end
        end
        CMD_FORCE: begin
          wp_next        = '0;
          remaining_next = CNT_W'(BUF_DEPTH);
          mode_next      = MODE_POST;
        end
        CMD_SWTRIG: begin
          if (mode == MODE_WAIT) begin
            remaining_next = post_length;
            mode_next      = MODE_POST;
          end
        end
        CMD_READ: begin
          if (mode == MODE_DONE) begin
            rd_en           = 1'b1;
            rd_written_next = CNT_W'(rd_addr) < fill;
            if (read_offset == ADDR_W'(BUF_DEPTH - 1)) begin
              rd_last_next     = 1'b1;
              read_offset_next = '0;
            end else begin
              read_offset_next = read_offset + ADDR_W'(1);
            end
          end
        end
        CMD_IDLE: begin
          mode_next = MODE_IDLE;
        end
        default: begin
        end
      endcase
    end

    if (cfg_valid) begin
      priority if (cfg_index == REG_DECIMATION) begin
        decimation_next = (cfg_data == '0) ? DEC_W'(1) : cfg_data;
        mode_next       = MODE_IDLE;
      end else if (cfg_index == REG_POST_LENGTH) begin
        post_length_next = (32'(post_raw) > 32'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH)
                                                            : CNT_W'(post_raw);
        mode_next        = MODE_IDLE;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      wp          <= '0;
      read_offset <= '0;
      fill        <= '0;
      remaining   <= '0;
      tick_count  <= '0;
      decimation  <= DEC_W'(1);
      post_length <= CNT_W'(512);
      out_valid   <= 1'b0;
    end else begin
      mode        <= mode_next;
      wp          <= wp_next;
      read_offset <= read_offset_next;
      fill        <= fill_next;
      remaining   <= remaining_next;
      tick_count  <= tick_count_next;
      decimation  <= decimation_next;
      post_length <= post_length_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_hit        <= rd_en;
      rd_written    <= rd_written_next;
      read_last     <= rd_last_next;
      capture_state <= mode_next;
    end
  end

  twc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_en),
    .waddr(wp),
    .wdata(sample_value),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(mem_q)
  );

  assign read_valid = rd_hit;
  assign read_data  = (rd_hit && rd_written) ? mem_q : '0;

  `TWC_ASSERT_IMP(a_last_needs_valid, out_valid && read_last, read_valid, "read_last without read_valid")
  `TWC_ASSERT_IMP(a_read_only_done, out_valid && read_valid, capture_state == MODE_DONE, "read outside finished capture")
  `TWC_ASSERT_IMP(a_fill_bound, 1'b1, fill <= CNT_W'(BUF_DEPTH), "fill count beyond ring depth")
  `TWC_ASSERT_NEXT(a_read_result, in_accept && !cfg_valid && command == CMD_READ && mode == MODE_DONE, out_valid && read_valid, "read transaction lost")

endmodule

`default_nettype wire

>>> bench/twc_capture_checker.sv
`timescale 1ns / 100ps
// Result checker for the triggered waveform capture channel: mirrors the ring,
// pointers, counters and registers from the accepted transactions and checks
// every result transaction against its prediction. Depends on twc_pkg.

module twc_capture_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  twc_pkg::cmd_t                      command,
  input  twc_pkg::data_t                     sample_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  twc_pkg::data_t                     read_data,
  input  logic                               read_valid,
  input  logic                               read_last,
  input  twc_pkg::mode_t                     capture_state,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [twc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 failures,
  output int                                 pending
);

  import twc_pkg::*;

  typedef struct packed {
    data_t data;
    logic  valid;
    logic  last;
    mode_t state;
  } capture_result_t;

  data_t            ring [BUF_DEPTH];
  addr_t            wr_ptr;
  addr_t            rd_ofs;
  logic [DEC_W-1:0] tick_cnt;
  logic [DEC_W-1:0] dec_reg;
  cnt_t             post_left;
  cnt_t             post_reg;
  mode_t            cur_mode;
  capture_result_t  expected_results [$];

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    cnt_t p;
    case (idx)
      REG_DECIMATION: begin
        dec_reg  = (d == '0) ? DEC_W'(1) : d;
        cur_mode = MODE_IDLE;
      end
      REG_POST_LENGTH: begin
        p = d[POST_W-1:0];
        if (p > BUF_DEPTH) p = cnt_t'(BUF_DEPTH);
        post_reg = p;
        cur_mode = MODE_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic predict_capture(input cmd_t c, input data_t v, output capture_result_t r);
    logic [SUM_W-1:0] idx;
    r = '0;
    case (c)
      CMD_TICK: begin
        if (cur_mode == MODE_WAIT || cur_mode == MODE_POST) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= dec_reg) begin
            tick_cnt = '0;
            ring[wr_ptr] = v;
            wr_ptr = (wr_ptr == addr_t'(BUF_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
            if (cur_mode == MODE_POST) begin
              if (post_left != '0) post_left = post_left - 1'b1;
              if (post_left == '0) begin
                cur_mode = MODE_DONE;
                rd_ofs   = '0;
              end
            end
          end
        end
      end
      CMD_START: begin
        if (cur_mode == MODE_IDLE) begin
          tick_cnt = '0;
          wr_ptr   = '0;
          rd_ofs   = '0;
          cur_mode = MODE_WAIT;
        end
      end
      CMD_FORCE: begin
        wr_ptr    = '0;
        post_left = cnt_t'(BUF_DEPTH);
        cur_mode  = MODE_POST;
      end
      CMD_SWTRIG: begin
        if (cur_mode == MODE_WAIT) begin
          post_left = post_reg;
          cur_mode  = MODE_POST;
        end
      end
      CMD_READ: begin
        if (cur_mode == MODE_DONE) begin
          idx = SUM_W'(wr_ptr) + SUM_W'(rd_ofs);
          if (idx >= BUF_DEPTH) idx = idx - SUM_W'(BUF_DEPTH);
          r.data  = ring[idx[ADDR_W-1:0]];
          r.valid = 1'b1;
          if (rd_ofs == addr_t'(BUF_DEPTH - 1)) begin
            r.last = 1'b1;
            rd_ofs = '0;
          end else begin
            rd_ofs = rd_ofs + 1'b1;
          end
        end
      end
      CMD_IDLE: cur_mode = MODE_IDLE;
      default: ;
    endcase
    r.state = cur_mode;
  endtask

  always @(posedge clk) begin
    capture_result_t want;
    if (rst) begin
      for (int i = 0; i < BUF_DEPTH; i++) ring[i] = '0;
      wr_ptr    = '0;
      rd_ofs    = '0;
      tick_cnt  = '0;
      post_left = '0;
      cur_mode  = MODE_IDLE;
      dec_reg   = DEC_W'(1);
      post_reg  = cnt_t'(512);
      expected_results.delete();
      failures  = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        predict_capture(command, sample_value, want);
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with none expected: read_data %h state %0d",
                 read_data, capture_state);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.data) begin
            $error("read_data: expected %h, got %h", want.data, read_data);
            failures++;
          end
          if (read_valid !== want.valid) begin
            $error("read_valid: expected %b, got %b", want.valid, read_valid);
            failures++;
          end
          if (read_last !== want.last) begin
            $error("read_last: expected %b, got %b", want.last, read_last);
            failures++;
          end
          if (capture_state !== want.state) begin
            $error("capture_state: expected %0d, got %0d", want.state, capture_state);
            failures++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Top of the capture channel bench: clock, reset, command and register stimulus
// with bursty sender and stalling receiver, and the verdict.
// Depends on twc_pkg, triggered_waveform_capture and twc_capture_checker.

module tb;
  import twc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TOTAL_ITEMS = 550;

  localparam cmd_t CMD_UNUSED_6 = 3'd6;
  localparam cmd_t CMD_UNUSED_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  cmd_t                  command;
  data_t                 sample_value;
  logic                  out_valid;
  logic                  out_stall;
  data_t                 read_data;
  logic                  read_valid;
  logic                  read_last;
  mode_t                 capture_state;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    pending;

  int                    burst_left;
  int                    items_sent;
  int                    cur_dec;
  int                    cur_post;
  int                    cycle_count;

  triggered_waveform_capture DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .sample_value  (sample_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .read_valid    (read_valid),
    .read_last     (read_last),
    .capture_state (capture_state),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  twc_capture_checker capture_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .sample_value  (sample_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .read_valid    (read_valid),
    .read_last     (read_last),
    .capture_state (capture_state),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .failures      (failures),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // receiver: free runs, random and periodic stalls, and long hold-offs
  initial begin
    int seg;
    int len;
    int kind;
    int k;
    out_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    seg = 0;
    forever begin
      if (seg == 2 || $urandom_range(0, 15) == 0) kind = 3;
      else kind = $urandom_range(0, 2);
      case (kind)
        0: begin
          len = $urandom_range(10, 60);
          repeat (len) begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
        end
        1: begin
          len = $urandom_range(20, 80);
          k = $urandom_range(20, 75);
          repeat (len) begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < k);
          end
        end
        2: begin
          len = $urandom_range(20, 80);
          k = $urandom_range(2, 5);
          for (int i = 0; i < len; i++) begin
            @(negedge clk);
            out_stall <= (i % k == 0);
          end
        end
        default: begin
          len = $urandom_range(100, 200);
          // start the hold-off while the sender is offering
          while (in_valid !== 1'b1) begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
          repeat (len) begin
            @(negedge clk);
            out_stall <= 1'b1;
          end
        end
      endcase
      seg++;
    end
  end

  // one command transaction, sent in bursts with random gaps between them
  task automatic send_cmd(input cmd_t c, input data_t v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    command      <= c;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_noisy_tick();
    if ($urandom_range(0, 19) == 0) send_cmd(cmd_t'($urandom_range(0, 7)), $urandom);
    else send_cmd(CMD_TICK, $urandom);
  endtask

  task automatic drain_channel();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_DECIMATION) cur_dec = (d == '0) ? 1 : int'(d);
    else if (idx == REG_POST_LENGTH)
      cur_post = (d[POST_W-1:0] > BUF_DEPTH) ? BUF_DEPTH : int'(d[POST_W-1:0]);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] dec, input logic [CFG_DATA_W-1:0] post);
    drain_channel();
    write_cfg(REG_DECIMATION, dec);
    write_cfg(REG_POST_LENGTH, post);
  endtask

  task automatic random_capture();
    int sel;
    int p;
    int n;
    logic [CFG_DATA_W-1:0] dec;
    if (cur_post > 20 || $urandom_range(0, 2) == 0) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) dec = '0;
      else if (sel == 1) dec = 16'hFFFF;
      else if (sel == 2) dec = CFG_DATA_W'($urandom_range(5, 300));
      else dec = CFG_DATA_W'($urandom_range(1, 4));
      p = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 20);
      reconfigure(dec, CFG_DATA_W'(($urandom_range(0, 31) << POST_W) | p));
    end
    send_cmd(CMD_START, $urandom);
    n = $urandom_range(0, 10);
    repeat (n) send_noisy_tick();
    sel = $urandom_range(0, 19);
    if (sel < 15) begin
      send_cmd(CMD_SWTRIG, $urandom);
      if (cur_dec <= 4) n = ((cur_post == 0) ? 1 : cur_post) * cur_dec + $urandom_range(0, 3);
      else n = $urandom_range(0, 6);
    end else if (sel < 18) begin
      send_cmd(CMD_FORCE, $urandom);
      n = $urandom_range(0, 8);
    end else begin
      n = $urandom_range(0, 4);
    end
    repeat (n) send_noisy_tick();
    n = $urandom_range(0, 10);
    repeat (n) send_cmd(CMD_READ, $urandom);
    sel = $urandom_range(0, 7);
    if (sel == 0) send_cmd(CMD_START, $urandom);
    if (sel != 1) send_cmd(CMD_IDLE, $urandom);
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    command      = CMD_TICK;
    sample_value = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DECIMATION;
    cfg_data     = '0;
    burst_left   = 0;
    items_sent   = 0;
    cur_dec      = 1;
    cur_post     = 512;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // zero decimation, zero post length, commands in the wrong modes
    reconfigure(16'd0, 16'd0);
    send_cmd(CMD_READ, 32'hFFFF_FFFF);
    send_cmd(CMD_TICK, 32'h1234_5678);
    send_cmd(CMD_SWTRIG, '0);
    send_cmd(CMD_UNUSED_6, 32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED_7, '0);
    send_cmd(CMD_START, '0);
    send_cmd(CMD_START, '0);
    send_cmd(CMD_TICK, 32'hFFFF_FFFF);
    send_cmd(CMD_TICK, 32'h0000_0000);
    send_cmd(CMD_SWTRIG, '0);
    send_cmd(CMD_TICK, 32'hA5A5_A5A5);
    send_cmd(CMD_TICK, 32'h5A5A_5A5A);
    send_cmd(CMD_START, '0);
    send_cmd(CMD_SWTRIG, '0);
    repeat (3) send_cmd(CMD_READ, '0);
    send_cmd(CMD_IDLE, '0);

    // decimation lowered under the running tick count, then a force trigger
    reconfigure(16'd5, 16'd3);
    send_cmd(CMD_START, '0);
    repeat (3) send_cmd(CMD_TICK, $urandom);
    send_cmd(CMD_IDLE, '0);
    drain_channel();
    write_cfg(REG_SPARE_2, 16'hFFFF);
    write_cfg(REG_SPARE_3, 16'h0000);
    write_cfg(REG_DECIMATION, 16'd2);
    send_cmd(CMD_FORCE, '0);
    repeat (2) send_cmd(CMD_TICK, $urandom);
    send_cmd(CMD_FORCE, '0);
    send_cmd(CMD_SWTRIG, '0);
    send_cmd(CMD_IDLE, '0);

    // post length saturated to the ring depth, capture still running
    reconfigure(16'd1, 16'hFFFF);
    send_cmd(CMD_START, '0);
    repeat (5) send_cmd(CMD_TICK, $urandom);
    send_cmd(CMD_SWTRIG, '0);
    repeat (20) send_cmd(CMD_TICK, $urandom);
    repeat (2) send_cmd(CMD_READ, '0);
    send_cmd(CMD_IDLE, '0);

    // force trigger with reads before the capture ends
    send_cmd(CMD_FORCE, '0);
    repeat (12) send_cmd(CMD_TICK, $urandom);
    repeat (2) send_cmd(CMD_READ, '0);
    send_cmd(CMD_IDLE, '0);

    while (items_sent < TOTAL_ITEMS) random_capture();

    drain_channel();
    if (failures == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
